// ===== sv/gmsd_pkg.sv =====
package gmsd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ScoreW   = 47;
  localparam int unsigned GapW     = 6;
  localparam int unsigned CountW   = 8;

  // Parameter defaults.
  localparam int unsigned MaxGapDef  = 64;
  localparam int unsigned SampleWDef = 32;

  // Largest representable score; sums clamp here.
  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  // Sequence counter stops here.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage

// ===== sv/gapped_max_sum_dp.sv =====
// Gapped maximum-sum scorer.
// Input channel: sample_i and last_item_i move as one beat when in_valid_i is high
// and in_stall_o is low. Feed a sequence from its last element to its first and
// mark the first array element with last_item_i.
// Output channel: one beat per input beat carrying score_o, best_so_far_o and
// sequence_done_o, taken when out_valid_o is high and out_stall_i is low.
// Configuration: cfg_we_i writes cfg_wdata_i into the gap register; write it only
// while the block is idle.
// Timing: past scores live in a history RAM with one read port and one write
// port, read one entry a cycle. An element that sees no look-back window goes
// straight to the final step; otherwise it reads n = min(2*gap+1, seen) - gap
// entries, then passes a drain step and the final step, where its result is
// loaded into the output register.
// A new beat is accepted while the previous result still sits in the output
// register; a stalled receiver only holds the block at its final step.
// Reset clears the gap, the sequence counter and the running best. The history
// RAM is not cleared: the sequence counter bounds every look-back to entries
// written in the current sequence, so no clearing pass is needed. After a beat
// with last_item_i set, the sequence state starts over.
module gapped_max_sum_dp #(
  parameter int unsigned MaxGap  = gmsd_pkg::MaxGapDef,
  parameter int unsigned SampleW = gmsd_pkg::SampleWDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SampleW-1:0]   sample_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gmsd_pkg::ScoreW-1:0] score_o,
  output logic [gmsd_pkg::ScoreW-1:0] best_so_far_o,
  output logic                        sequence_done_o,
  input  logic                        cfg_we_i,
  input  logic [gmsd_pkg::GapW-1:0]   cfg_wdata_i
);

  localparam int unsigned ScoreW  = gmsd_pkg::ScoreW;
  localparam int unsigned GapW    = gmsd_pkg::GapW;
  localparam int unsigned CountW  = gmsd_pkg::CountW;
  localparam int unsigned HistD   = 2 * MaxGap;
  localparam int unsigned AddrW   = (HistD > 2) ? $clog2(HistD) : 1;
  localparam int unsigned GapLim  = MaxGap - 1;

  // Sequencer codes.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [GapW-1:0]         gap_q;
  logic [CountW-1:0]       count_q, count_d;
  logic [ScoreW-1:0]       best_q, best_d;
  logic [AddrW-1:0]        wp_q;
  logic [AddrW-1:0]        rp_q, rp_d;
  logic [CountW-1:0]       rem_q, rem_d;
  logic [ScoreW-1:0]       x_q, x_d;
  logic                    rd_vld_q;
  logic [ScoreW-1:0]       rd_data_q;
  logic signed [SampleW-1:0] sample_q;
  logic                    last_q;
  logic                    out_valid_q;
  logic [ScoreW-1:0]       score_q;
  logic [ScoreW-1:0]       best_out_q;
  logic                    done_q;

  logic [ScoreW-1:0]       hist_mem [2**AddrW];

  logic                    in_fire;
  logic                    fin_fire;
  logic                    rd_en;
  logic [GapW-1:0]         g_eff;
  logic [CountW-1:0]       lo;
  logic [CountW-1:0]       hi;
  logic [CountW-1:0]       span;
  logic [ScoreW-1:0]       pos_val;
  logic [ScoreW:0]         sum;
  logic [ScoreW-1:0]       score_new;
  logic [CountW-1:0]       count_inc;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign rd_en    = (state_q == S_READ);

  // Effective gap and look-back window for the incoming beat.
  always_comb begin
    if (32'(gap_q) > GapLim) begin
      g_eff = GapW'(GapLim);
    end else begin
      g_eff = gap_q;
    end
    lo   = CountW'(g_eff) + CountW'(1);
    span = CountW'({g_eff, 1'b1});
    hi   = (span > count_q) ? count_q : span;
  end

  // Score: window maximum plus the positive part of the sample, clamped.
  always_comb begin
    if (sample_q[SampleW-1]) begin
      pos_val = '0;
    end else begin
      pos_val = ScoreW'(sample_q[SampleW-2:0]);
    end
    sum = {1'b0, x_q} + {1'b0, pos_val};
    score_new = sum[ScoreW] ? gmsd_pkg::ScoreMax : sum[ScoreW-1:0];
    count_inc = (count_q == gmsd_pkg::CountMax) ? count_q : count_q + CountW'(1);
  end

  // Sequencer and window accumulation.
  always_comb begin
    state_d = state_q;
    rp_d    = rp_q;
    rem_d   = rem_q;
    x_d     = x_q;
    count_d = count_q;
    best_d  = best_q;
    if (rd_vld_q && (rd_data_q > x_q)) begin
      x_d = rd_data_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_d   = '0;
          rp_d  = wp_q - AddrW'(lo);
          rem_d = hi - lo;
          if (count_q <= CountW'(g_eff)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rp_d = rp_q - AddrW'(1);
        if (rem_q == '0) begin
          state_d = S_DRAIN;
        end else begin
          rem_d = rem_q - CountW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) begin
          state_d = S_IDLE;
          if (last_q) begin
            count_d = '0;
            best_d  = '0;
          end else begin
            count_d = count_inc;
            best_d  = (score_new > best_q) ? score_new : best_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gap_q       <= '0;
      count_q     <= '0;
      best_q      <= '0;
      wp_q        <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      best_q   <= best_d;
      rd_vld_q <= rd_en;
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (fin_fire) begin
        wp_q <= wp_q + AddrW'(1);
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rp_q  <= rp_d;
    rem_q <= rem_d;
    x_q   <= x_d;
    if (in_fire) begin
      sample_q <= sample_i;
      last_q   <= last_item_i;
    end
    if (fin_fire) begin
      score_q    <= score_new;
      best_out_q <= (score_new > best_q) ? score_new : best_q;
      done_q     <= last_q;
    end
  end

  // History RAM: one read port, one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      hist_mem[wp_q] <= score_new;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rp_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign score_o         = score_q;
  assign best_so_far_o   = best_out_q;
  assign sequence_done_o = done_q;

`ifndef SYNTHESIS
  // The reported running best never falls below the reported score.
  a_best_ge_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_so_far_o >= score_o))
    else $error("best_so_far below score");

  // The last read of a window always delivers its data in the drain step.
  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> rd_vld_q)
    else $error("drain step without read data");

  // Finishing the final beat of a sequence clears the sequence state.
  a_seq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && last_q) |=> ((count_q == '0) && (best_q == '0)))
    else $error("sequence state not cleared");

  // An accepted beat always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_READ || state_q == S_FIN))
    else $error("accepted beat did not start work");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !fin_fire)
    else $error("output register overwritten");
`endif

endmodule

// ===== sim/gapped_max_sum_dp_test.sv =====
`timescale 1ns / 100ps

module gapped_max_sum_dp_test;

  localparam int unsigned SampleW    = gmsd_pkg::SampleWDef;
  localparam int unsigned ScoreW     = gmsd_pkg::ScoreW;
  localparam int unsigned GapW       = gmsd_pkg::GapW;
  localparam int unsigned HistDepth  = 2 * gmsd_pkg::MaxGapDef;
  localparam int unsigned MaxGapCfg  = gmsd_pkg::MaxGapDef - 1;
  localparam int unsigned HoldCycles = 200;
  // Leave some margin after the worst element before a register write.
  localparam int unsigned SettleCycles = 80;

  // One output beat as the block should present it.
  typedef struct {
    logic [ScoreW-1:0] score;
    logic [ScoreW-1:0] best;
    logic              done;
  } score_beat_t;

  // Tracks the gapped-sum recurrence and holds the results still owed by the block.
  class gap_sum_scoreboard;
    logic [ScoreW-1:0] history [HistDepth];
    int unsigned       seen;
    logic [ScoreW-1:0] best_score;
    logic [GapW-1:0]   gap_cfg;
    score_beat_t       owed_q [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      clear_sequence();
      gap_cfg = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_sequence();
      foreach (history[i]) history[i] = '0;
      seen       = 0;
      best_score = '0;
    endfunction

    function void set_gap(logic [GapW-1:0] g);
      gap_cfg = g;
    endfunction

    // Work out the score of an accepted element and queue the expected beat.
    function void note_beat(logic signed [SampleW-1:0] sample, logic last);
      int unsigned       g;
      int unsigned       hi;
      logic [ScoreW-1:0] x;
      longint            cand;
      longint            pick;
      score_beat_t       exp_beat;

      g = gap_cfg;
      if (g > MaxGapCfg) g = MaxGapCfg;

      if (seen <= g) begin
        pick = longint'(sample);
        if (pick < 0) pick = 0;
      end else begin
        // Largest earlier score in the window gap+1 .. 2*gap+1 steps back.
        x  = '0;
        hi = 2 * g + 1;
        if (hi > seen) hi = seen;
        for (int unsigned d = g + 1; d <= hi && d <= HistDepth; d++) begin
          if (history[d-1] > x) x = history[d-1];
        end
        pick = longint'(x);
        cand = longint'(x) + longint'(sample);
        if (cand > pick) pick = cand;
      end
      if (pick > longint'(gmsd_pkg::ScoreMax)) pick = longint'(gmsd_pkg::ScoreMax);

      for (int i = HistDepth - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = pick[ScoreW-1:0];
      if (seen < gmsd_pkg::CountMax) seen++;
      if (history[0] > best_score) best_score = history[0];

      exp_beat.score = history[0];
      exp_beat.best  = best_score;
      exp_beat.done  = last;
      owed_q.push_back(exp_beat);

      if (last) clear_sequence();
    endfunction

    // Compare an accepted output beat against the oldest expectation.
    function void check_beat(logic [ScoreW-1:0] score, logic [ScoreW-1:0] best, logic done);
      score_beat_t exp_beat;

      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result beat, score %0d best %0d done %0b",
                 $time, score, best, done);
        errors++;
        return;
      end
      exp_beat = owed_q.pop_front();
      checked++;
      if (score !== exp_beat.score) begin
        $display("%0t: score mismatch, expected %0d actual %0d", $time, exp_beat.score, score);
        errors++;
      end
      if (best !== exp_beat.best) begin
        $display("%0t: best_so_far mismatch, expected %0d actual %0d",
                 $time, exp_beat.best, best);
        errors++;
      end
      if (done !== exp_beat.done) begin
        $display("%0t: sequence_done mismatch, expected %0b actual %0b",
                 $time, exp_beat.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i;
  logic                      last_item_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [ScoreW-1:0]         score_o;
  logic [ScoreW-1:0]         best_so_far_o;
  logic                      sequence_done_o;
  logic                      cfg_we_i;
  logic [GapW-1:0]           cfg_wdata_i;

  gap_sum_scoreboard sb;
  bit                quiet;
  bit                hold_req;
  int unsigned       items_sent;
  int unsigned       sequences_closed;
  int unsigned       gaps_written;

  gapped_max_sum_dp DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .score_o         (score_o),
    .best_so_far_o   (best_so_far_o),
    .sequence_done_o (sequence_done_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Check every result beat taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(score_o, best_so_far_o, sequence_done_o);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Give up if the block hangs.
  initial begin
    #10_000_000;
    $display("gapped_max_sum_dp_test NOT OK");
    $finish;
  end

  // Moderate positive values most often so sums build up, with extremes, raw random values and negatives mixed in.
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SampleW-1){1'b1}}};
      1:       return {1'b1, {(SampleW-1){1'b0}}};
      2:       return '0;
      3, 4:    return $urandom;
      5, 6:    return SampleW'(-int'($urandom_range(1, 5000)));
      default: return SampleW'($urandom_range(0, 100000));
    endcase
  endfunction

  // Offer one input beat and wait until the block takes it.
  task automatic put_beat(logic [SampleW-1:0] sample, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= sample;
    last_item_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(sample, last);
    items_sent++;
    if (last) sequences_closed++;
  endtask

  // Lower valid and wait until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Gap is only written with the block idle.
  task automatic write_gap(logic [GapW-1:0] g);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_gap(g);
    gaps_written++;
  endtask

  task automatic send_sequence(int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) begin
      put_beat(pick_sample(), close && (i == len - 1));
    end
  endtask

  // Random sequences of lengths around the look-back window; the last one may stay open.
  task automatic run_phase(logic [GapW-1:0] g, int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          close;

    write_gap(g);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 2 * g + 6);
      if (len > n_items - sent) len = n_items - sent;
      close = (sent + len < n_items) ? 1'b1 : 1'($urandom_range(0, 1));
      send_sequence(len, close);
      sent += len;
    end
  endtask

  initial begin
    int unsigned phase_gaps [8];

    sb               = new();
    quiet            = 1'b0;
    hold_req         = 1'b0;
    items_sent       = 0;
    sequences_closed = 0;
    gaps_written     = 0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    sample_i         = '0;
    last_item_i      = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    phase_gaps       = '{0, 1, 3, 7, 15, 31, 5, 0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme samples with no gap.
    write_gap('0);
    put_beat(32'h7fff_ffff, 1'b0);
    put_beat(32'h7fff_ffff, 1'b0);
    put_beat(32'h8000_0000, 1'b0);
    put_beat(32'h0000_0000, 1'b0);
    put_beat(32'hffff_ffff, 1'b0);
    put_beat(32'h0000_0001, 1'b0);
    put_beat(32'h8000_0000, 1'b1);

    // Directed: gap of one, a sequence that ends on a negative element.
    write_gap(GapW'(1));
    put_beat(32'd5, 1'b0);
    put_beat(-32'sd3, 1'b0);
    put_beat(32'd7, 1'b0);
    put_beat(32'h8000_0000, 1'b0);
    put_beat(32'h7fff_ffff, 1'b0);
    put_beat(32'd2, 1'b0);
    put_beat(-32'sd9, 1'b1);

    // Directed: gap changes halfway through a sequence; kept scores stay.
    write_gap(GapW'(2));
    put_beat(32'd100, 1'b0);
    put_beat(32'd40, 1'b0);
    put_beat(-32'sd20, 1'b0);
    put_beat(32'd60, 1'b0);
    write_gap('0);
    put_beat(32'd10, 1'b0);
    put_beat(-32'sd1, 1'b0);
    put_beat(32'd30, 1'b1);

    // Widest gap: one sequence long enough to fill the whole look-back window.
    write_gap(GapW'(MaxGapCfg));
    send_sequence(140, 1'b1);

    // A sequence past the counter limit, with the receiver held off at its start.
    write_gap(GapW'(2));
    hold_req = 1'b1;
    send_sequence(300, 1'b1);

    foreach (phase_gaps[p]) run_phase(GapW'(phase_gaps[p]), 60);
    run_phase(GapW'(MaxGapCfg), 40);

    // Last part runs back to back with no idling on either side.
    quiet = 1'b1;
    run_phase(GapW'($urandom_range(0, MaxGapCfg)), 80);
    drain();

    $display("Sent %0d elements in %0d closed sequences over %0d gap settings.",
             items_sent, sequences_closed, gaps_written);
    $display("Checked %0d result beats, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("gapped_max_sum_dp_test OK");
    end else begin
      $display("gapped_max_sum_dp_test NOT OK");
    end
    $finish;
  end

endmodule
